FILE: rtl/core/lhtr_pkg.sv
package lhtr_pkg;

    localparam int ALPHA_TABLE_ENTRIES = 257;
    localparam int GENERATION_BITS     = 32;

    localparam int LEVEL_W   = 17;
    localparam int RATE_W    = 16;
    localparam int TIME_W    = 16;
    localparam int CODE_W    = 4;
    localparam int FLAGS_W   = 6;
    localparam int REQ_W     = 2;
    localparam int DERIV_W   = 3;
    localparam int GEN_OUT_W = 32;

    localparam int DT_W     = 13;
    localparam int DT_SHIFT = 12;
    localparam int IDX_W    = $clog2(ALPHA_TABLE_ENTRIES);
    localparam int IDX_PROD_W = 2 * DT_W;
    localparam int PROD_W   = 2 * LEVEL_W - 1;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_W   = 16;

    localparam logic [LEVEL_W-1:0] ONE_Q16       = 17'd65536;
    localparam logic [DT_W-1:0]    DT_MAX        = 13'd4096;
    localparam logic [RATE_W-1:0]  REFRESH_MIN   = 16'd7680;
    localparam logic [RATE_W-1:0]  REFRESH_MAX   = 16'd61440;
    localparam logic [RATE_W-1:0]  REFRESH_RESET = 16'd15360;

    // Lifecycle event codes.
    localparam logic [CODE_W-1:0] EV_CREATE         = 4'd0;
    localparam logic [CODE_W-1:0] EV_START          = 4'd1;
    localparam logic [CODE_W-1:0] EV_RESUME         = 4'd2;
    localparam logic [CODE_W-1:0] EV_PAUSE          = 4'd3;
    localparam logic [CODE_W-1:0] EV_STOP           = 4'd4;
    localparam logic [CODE_W-1:0] EV_DESTROY        = 4'd5;
    localparam logic [CODE_W-1:0] EV_SURF_CREATED   = 4'd6;
    localparam logic [CODE_W-1:0] EV_SURF_DESTROYED = 4'd7;
    localparam logic [CODE_W-1:0] EV_FOCUS_GAINED   = 4'd8;
    localparam logic [CODE_W-1:0] EV_FOCUS_LOST     = 4'd9;
    localparam logic [CODE_W-1:0] EV_LOW_MEMORY     = 4'd10;

    // Lifecycle flag positions.
    localparam int FL_CREATED = 0;
    localparam int FL_STARTED = 1;
    localparam int FL_RESUMED = 2;
    localparam int FL_FOCUSED = 3;
    localparam int FL_SURFACE = 4;
    localparam int FL_EXITING = 5;

    // Request and derived bit positions.
    localparam int RQ_RECREATE = 0;
    localparam int RQ_TRIM     = 1;
    localparam int DV_SIM      = 0;
    localparam int DV_RENDER   = 1;
    localparam int DV_THROTTLE = 2;

    typedef logic [LEVEL_W-1:0] t_alpha_tab [ALPHA_TABLE_ENTRIES];

    typedef struct packed {
        logic load_prod;
        logic load_level;
        logic apply;
    } t_lane_ctrl;

    typedef struct packed {
        logic [FLAGS_W-1:0]         flags;
        logic [REQ_W-1:0]           req;
        logic [DERIV_W-1:0]         derived;
        logic [GENERATION_BITS-1:0] gen;
    } t_life_state;

    // Unsigned shift-and-subtract quotient, evaluated only while the table is built.
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] dnm);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= dnm) begin
                rem    = rem - dnm;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Step factor 1 - exp(-k / (2 * (entries - 1))) in Q0.16, from an
    // alternating series evaluated in Q2.48.
    function automatic t_alpha_tab f_build_alpha();
        t_alpha_tab  tab;
        logic [63:0] one;
        logic [63:0] den;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        logic [63:0] a;
        one = 64'd1 << 48;
        den = 64'(2 * (ALPHA_TABLE_ENTRIES - 1));
        for (int k = 0; k < ALPHA_TABLE_ENTRIES; k++) begin
            term = one;
            pos  = one;
            neg  = 64'd0;
            for (int n = 1; n < 40; n++) begin
                if (term != 64'd0) begin
                    term = f_udiv(term * 64'(k), den * 64'(n));
                    if ((n % 2) == 1) begin
                        neg = neg + term;
                    end else begin
                        pos = pos + term;
                    end
                end
            end
            e = pos - neg;
            a = (e >= one) ? 64'd0 : (one - e);
            tab[k] = LEVEL_W'((a + (64'd1 << 31)) >> 32);
        end
        return tab;
    endfunction

    localparam t_alpha_tab ALPHA_TAB = f_build_alpha();

endpackage

FILE: rtl/core/lhtr_in_if.sv
interface lhtr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [lhtr_pkg::CODE_W-1:0] event_code;
    logic                        cpu_valid;
    logic [lhtr_pkg::LEVEL_W-1:0] cpu_target;
    logic                        gpu_valid;
    logic [lhtr_pkg::LEVEL_W-1:0] gpu_target;
    logic [lhtr_pkg::LEVEL_W-1:0] thermal_target;
    logic [lhtr_pkg::RATE_W-1:0] refresh_sample;
    logic [lhtr_pkg::TIME_W-1:0] elapsed;

    modport source (
        output valid, mode, event_code, cpu_valid, cpu_target, gpu_valid, gpu_target,
               thermal_target, refresh_sample, elapsed,
        input  ready
    );
    modport sink (
        input  valid, mode, event_code, cpu_valid, cpu_target, gpu_valid, gpu_target,
               thermal_target, refresh_sample, elapsed,
        output ready
    );
endinterface

FILE: rtl/core/lhtr_out_if.sv
interface lhtr_out_if;
    logic                           valid;
    logic                           ready;
    logic [lhtr_pkg::FLAGS_W-1:0]   life_flags;
    logic [lhtr_pkg::REQ_W-1:0]     request_bits;
    logic [lhtr_pkg::DERIV_W-1:0]   derived_bits;
    logic [lhtr_pkg::GEN_OUT_W-1:0] generation_count;
    logic [lhtr_pkg::LEVEL_W-1:0]   cpu_smoothed;
    logic [lhtr_pkg::LEVEL_W-1:0]   gpu_smoothed;
    logic [lhtr_pkg::LEVEL_W-1:0]   thermal_smoothed;
    logic [lhtr_pkg::RATE_W-1:0]    refresh_rate;

    modport source (
        output valid, life_flags, request_bits, derived_bits, generation_count,
               cpu_smoothed, gpu_smoothed, thermal_smoothed, refresh_rate,
        input  ready
    );
    modport sink (
        input  valid, life_flags, request_bits, derived_bits, generation_count,
               cpu_smoothed, gpu_smoothed, thermal_smoothed, refresh_rate,
        output ready
    );
endinterface

FILE: rtl/core/lhtr_smooth_lane.sv
module lhtr_smooth_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lhtr_pkg::t_lane_ctrl         i_ctrl,
    input  logic [lhtr_pkg::LEVEL_W-1:0] i_target,
    input  logic [lhtr_pkg::LEVEL_W-1:0] i_alpha,
    input  logic [lhtr_pkg::LEVEL_W-1:0] i_one_minus_alpha,
    output logic [lhtr_pkg::LEVEL_W-1:0] o_level
);

    logic [lhtr_pkg::PROD_W-1:0]  r_ta;
    logic [lhtr_pkg::LEVEL_W-1:0] r_level;
    logic [lhtr_pkg::SUM_W-1:0]   n_sum;
    logic [lhtr_pkg::LEVEL_W-1:0] n_level;

    // The target product does not depend on the level, so it is formed a stage early.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_prod) begin
            r_ta <= lhtr_pkg::PROD_W'(i_target) * lhtr_pkg::PROD_W'(i_alpha);
        end
    end

    // level + floor((target - level) * alpha / 2^16) rewritten as
    // floor((level * (1 - alpha) + target * alpha) / 2^16), which stays between
    // level and target and so never leaves the 0..1.0 range.
    always_comb begin
        n_sum = lhtr_pkg::SUM_W'(lhtr_pkg::PROD_W'(r_level) *
                                 lhtr_pkg::PROD_W'(i_one_minus_alpha))
              + lhtr_pkg::SUM_W'(r_ta);
        n_level = lhtr_pkg::LEVEL_W'(n_sum >> lhtr_pkg::FRAC_W);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= lhtr_pkg::ONE_Q16;
        end else if (i_ctrl.load_level && i_ctrl.apply) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

FILE: rtl/core/lhtr_life_unit.sv
module lhtr_life_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [lhtr_pkg::CODE_W-1:0] i_code,
    output lhtr_pkg::t_life_state       o_state
);

    lhtr_pkg::t_life_state r_state;
    lhtr_pkg::t_life_state n_state;
    logic                  n_bump;
    logic                  n_sim;

    always_comb begin
        n_state         = r_state;
        n_state.req     = '0;
        n_bump          = 1'b0;
        unique case (i_code)
            lhtr_pkg::EV_CREATE: begin
                n_state.flags[lhtr_pkg::FL_CREATED] = 1'b1;
                n_state.flags[lhtr_pkg::FL_EXITING] = 1'b0;
                n_bump = 1'b1;
            end
            lhtr_pkg::EV_START: begin
                n_state.flags[lhtr_pkg::FL_STARTED] = 1'b1;
            end
            lhtr_pkg::EV_RESUME: begin
                n_state.flags[lhtr_pkg::FL_RESUMED] = 1'b1;
            end
            lhtr_pkg::EV_PAUSE: begin
                n_state.flags[lhtr_pkg::FL_RESUMED] = 1'b0;
            end
            lhtr_pkg::EV_STOP: begin
                n_state.flags[lhtr_pkg::FL_STARTED] = 1'b0;
                n_state.flags[lhtr_pkg::FL_RESUMED] = 1'b0;
            end
            lhtr_pkg::EV_DESTROY: begin
                n_state.flags = '0;
                n_state.flags[lhtr_pkg::FL_EXITING] = 1'b1;
                n_bump = 1'b1;
            end
            lhtr_pkg::EV_SURF_CREATED: begin
                if (!r_state.flags[lhtr_pkg::FL_SURFACE]) begin
                    n_state.flags[lhtr_pkg::FL_SURFACE] = 1'b1;
                    n_state.req[lhtr_pkg::RQ_RECREATE]  = 1'b1;
                    n_bump = 1'b1;
                end
            end
            lhtr_pkg::EV_SURF_DESTROYED: begin
                if (r_state.flags[lhtr_pkg::FL_SURFACE]) begin
                    n_state.flags[lhtr_pkg::FL_SURFACE] = 1'b0;
                    n_bump = 1'b1;
                end
            end
            lhtr_pkg::EV_FOCUS_GAINED: begin
                n_state.flags[lhtr_pkg::FL_FOCUSED] = 1'b1;
            end
            lhtr_pkg::EV_FOCUS_LOST: begin
                n_state.flags[lhtr_pkg::FL_FOCUSED] = 1'b0;
            end
            lhtr_pkg::EV_LOW_MEMORY: begin
                n_state.req[lhtr_pkg::RQ_TRIM] = 1'b1;
            end
            default: begin
            end
        endcase

        if (n_bump) begin
            n_state.gen = r_state.gen + lhtr_pkg::GENERATION_BITS'(1);
        end

        n_sim = n_state.flags[lhtr_pkg::FL_CREATED] && n_state.flags[lhtr_pkg::FL_STARTED]
             && n_state.flags[lhtr_pkg::FL_RESUMED] && !n_state.flags[lhtr_pkg::FL_EXITING];
        n_state.derived[lhtr_pkg::DV_SIM]      = n_sim;
        n_state.derived[lhtr_pkg::DV_RENDER]   = n_sim && n_state.flags[lhtr_pkg::FL_SURFACE];
        n_state.derived[lhtr_pkg::DV_THROTTLE] = !n_state.flags[lhtr_pkg::FL_RESUMED]
                                              || !n_state.flags[lhtr_pkg::FL_FOCUSED]
                                              || !n_state.flags[lhtr_pkg::FL_SURFACE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_load) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

FILE: rtl/core/lifecycle_and_headroom_tracker_top.sv
// Channel   Direction  Transfer when        Carries
// i_in      sink       valid && ready       event code or telemetry sample
// o_out     source     valid && ready       full tracker state after the item
//
// One item per cycle is sustained while o_out.ready stays high. An input passes a
// register after the step-factor table lookup, one after the target products,
// then the state update (one multiply and add per lane) that raises o_out.valid.
// Reset (synchronous, active low) clears the lifecycle state and sets the levels
// to 1.0 and the refresh rate to 60 Hz. While a result waits, two more items
// are taken into the pipeline before i_in.ready drops.
module lifecycle_and_headroom_tracker_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lhtr_in_if.sink       i_in,
    lhtr_out_if.source    o_out
);

    localparam int EXT_W = lhtr_pkg::GEN_OUT_W + lhtr_pkg::GENERATION_BITS;

    logic r_v1;
    logic r_v2;
    logic r_ov;
    logic adv1;
    logic adv2;
    logic adv_out;

    // Stage 1: saturated inputs and step factor.
    logic                          r_s1_mode;
    logic [lhtr_pkg::CODE_W-1:0]   r_s1_code;
    logic                          r_s1_cpu_vld;
    logic                          r_s1_gpu_vld;
    logic [lhtr_pkg::LEVEL_W-1:0]  r_s1_cpu_tgt;
    logic [lhtr_pkg::LEVEL_W-1:0]  r_s1_gpu_tgt;
    logic [lhtr_pkg::LEVEL_W-1:0]  r_s1_thm_tgt;
    logic [lhtr_pkg::LEVEL_W-1:0]  r_s1_alpha;
    logic                          r_s1_rf_vld;
    logic [lhtr_pkg::RATE_W-1:0]   r_s1_rf;

    // Stage 2: control that rides along with the lane products.
    logic                          r_s2_mode;
    logic [lhtr_pkg::CODE_W-1:0]   r_s2_code;
    logic                          r_s2_cpu_vld;
    logic                          r_s2_gpu_vld;
    logic [lhtr_pkg::LEVEL_W-1:0]  r_s2_oma;
    logic                          r_s2_rf_vld;
    logic [lhtr_pkg::RATE_W-1:0]   r_s2_rf;

    logic [lhtr_pkg::RATE_W-1:0]   r_refresh;

    logic [lhtr_pkg::DT_W-1:0]       n_dt;
    logic [lhtr_pkg::IDX_PROD_W-1:0] n_idx_prod;
    logic [lhtr_pkg::IDX_W-1:0]      n_idx;
    logic [lhtr_pkg::LEVEL_W-1:0]    n_cpu_tgt;
    logic [lhtr_pkg::LEVEL_W-1:0]    n_gpu_tgt;
    logic [lhtr_pkg::LEVEL_W-1:0]    n_thm_tgt;

    lhtr_pkg::t_lane_ctrl  cpu_ctrl;
    lhtr_pkg::t_lane_ctrl  gpu_ctrl;
    lhtr_pkg::t_lane_ctrl  thm_ctrl;
    lhtr_pkg::t_life_state life_state;

    logic [lhtr_pkg::LEVEL_W-1:0] cpu_level;
    logic [lhtr_pkg::LEVEL_W-1:0] gpu_level;
    logic [lhtr_pkg::LEVEL_W-1:0] thm_level;
    logic [EXT_W-1:0]             gen_ext;

    // The state registers double as the output register: a new item updates the
    // state only when the previous result has been taken.
    assign adv_out    = r_v2 && (!r_ov || o_out.ready);
    assign adv2       = r_v1 && (!r_v2 || adv_out);
    assign i_in.ready = !r_v1 || adv2;
    assign adv1       = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= 1'b1;
            end else if (adv2) begin
                r_v1 <= 1'b0;
            end
            if (adv2) begin
                r_v2 <= 1'b1;
            end else if (adv_out) begin
                r_v2 <= 1'b0;
            end
            if (adv_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_comb begin
        n_dt = (i_in.elapsed > lhtr_pkg::TIME_W'(lhtr_pkg::DT_MAX))
             ? lhtr_pkg::DT_MAX : lhtr_pkg::DT_W'(i_in.elapsed);
        n_idx_prod = lhtr_pkg::IDX_PROD_W'(n_dt)
                   * lhtr_pkg::IDX_PROD_W'(lhtr_pkg::ALPHA_TABLE_ENTRIES - 1);
        n_idx = lhtr_pkg::IDX_W'(n_idx_prod >> lhtr_pkg::DT_SHIFT);
        n_cpu_tgt = (i_in.cpu_target > lhtr_pkg::ONE_Q16) ? lhtr_pkg::ONE_Q16
                                                          : i_in.cpu_target;
        n_gpu_tgt = (i_in.gpu_target > lhtr_pkg::ONE_Q16) ? lhtr_pkg::ONE_Q16
                                                          : i_in.gpu_target;
        n_thm_tgt = (i_in.thermal_target > lhtr_pkg::ONE_Q16) ? lhtr_pkg::ONE_Q16
                                                              : i_in.thermal_target;
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_mode    <= i_in.mode;
            r_s1_code    <= i_in.event_code;
            r_s1_cpu_vld <= i_in.cpu_valid;
            r_s1_gpu_vld <= i_in.gpu_valid;
            r_s1_cpu_tgt <= n_cpu_tgt;
            r_s1_gpu_tgt <= n_gpu_tgt;
            r_s1_thm_tgt <= n_thm_tgt;
            r_s1_alpha   <= lhtr_pkg::ALPHA_TAB[n_idx];
            r_s1_rf_vld  <= (i_in.refresh_sample >= lhtr_pkg::REFRESH_MIN);
            r_s1_rf      <= (i_in.refresh_sample > lhtr_pkg::REFRESH_MAX)
                          ? lhtr_pkg::REFRESH_MAX : i_in.refresh_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_mode    <= r_s1_mode;
            r_s2_code    <= r_s1_code;
            r_s2_cpu_vld <= r_s1_cpu_vld;
            r_s2_gpu_vld <= r_s1_gpu_vld;
            r_s2_oma     <= lhtr_pkg::ONE_Q16 - r_s1_alpha;
            r_s2_rf_vld  <= r_s1_rf_vld;
            r_s2_rf      <= r_s1_rf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refresh <= lhtr_pkg::REFRESH_RESET;
        end else if (adv_out && r_s2_mode && r_s2_rf_vld) begin
            r_refresh <= r_s2_rf;
        end
    end

    always_comb begin
        cpu_ctrl = '{load_prod: adv2, load_level: adv_out, apply: r_s2_mode && r_s2_cpu_vld};
        gpu_ctrl = '{load_prod: adv2, load_level: adv_out, apply: r_s2_mode && r_s2_gpu_vld};
        thm_ctrl = '{load_prod: adv2, load_level: adv_out, apply: r_s2_mode};
    end

    lhtr_smooth_lane u_cpu_lane (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (cpu_ctrl),
        .i_target          (r_s1_cpu_tgt),
        .i_alpha           (r_s1_alpha),
        .i_one_minus_alpha (r_s2_oma),
        .o_level           (cpu_level)
    );

    lhtr_smooth_lane u_gpu_lane (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (gpu_ctrl),
        .i_target          (r_s1_gpu_tgt),
        .i_alpha           (r_s1_alpha),
        .i_one_minus_alpha (r_s2_oma),
        .o_level           (gpu_level)
    );

    lhtr_smooth_lane u_thm_lane (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (thm_ctrl),
        .i_target          (r_s1_thm_tgt),
        .i_alpha           (r_s1_alpha),
        .i_one_minus_alpha (r_s2_oma),
        .o_level           (thm_level)
    );

    lhtr_life_unit u_life (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv_out && !r_s2_mode),
        .i_code  (r_s2_code),
        .o_state (life_state)
    );

    assign gen_ext = {lhtr_pkg::GEN_OUT_W'(0), life_state.gen};

    assign o_out.valid            = r_ov;
    assign o_out.life_flags       = life_state.flags;
    assign o_out.request_bits     = life_state.req;
    assign o_out.derived_bits     = life_state.derived;
    assign o_out.generation_count = gen_ext[lhtr_pkg::GEN_OUT_W-1:0];
    assign o_out.cpu_smoothed     = cpu_level;
    assign o_out.gpu_smoothed     = gpu_level;
    assign o_out.thermal_smoothed = thm_level;
    assign o_out.refresh_rate     = r_refresh;

    a_levels_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cpu_level <= lhtr_pkg::ONE_Q16) && (gpu_level <= lhtr_pkg::ONE_Q16)
        && (thm_level <= lhtr_pkg::ONE_Q16))
        else $error("smoothed headroom above 1.0");

    a_refresh_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_refresh >= lhtr_pkg::REFRESH_MIN) && (r_refresh <= lhtr_pkg::REFRESH_MAX))
        else $error("held refresh rate out of range");

    a_gen_moves_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(life_state.gen) |-> $past(adv_out && !r_s2_mode))
        else $error("generation changed without an event update");

    a_levels_hold_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(adv_out && !r_s2_mode) |-> ($stable(cpu_level) && $stable(gpu_level)
        && $stable(thm_level) && $stable(r_refresh)))
        else $error("telemetry state changed on a lifecycle event");

endmodule
